// ===== rtl/core/lmss_pkg.sv =====
// ----------------------------------------------------------------------------
// lmss_pkg
// Shared codes, widths, types and helpers of the LED matrix subframe scanner.
// ----------------------------------------------------------------------------
package lmss_pkg;

    // Field widths of the channels.
    localparam int OP_W      = 2;
    localparam int PIX_X_W   = 7;
    localparam int PIX_Y_W   = 4;
    localparam int VALUE_W   = 8;
    localparam int ROW_OUT_W = 4;
    localparam int REG_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Operation codes carried by the input beat.
    localparam logic [OP_W-1:0] OP_WR_PIXEL = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_GAMMA = 2'd1;
    localparam logic [OP_W-1:0] OP_SCAN     = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SUBFRAME_TOTAL    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBFRAMES_PER_ROW = 1'b1;

    localparam logic [REG_W-1:0] REG_RESET = 7'd8;
    localparam logic [REG_W-1:0] REG_MAX   = 7'd64;

    // Shared divider: dividend holds 255*(2s+1) for s up to 63, divisor 2*64.
    localparam int DIVIDEND_W = 15;
    localparam int DIVISOR_W  = 8;

    typedef struct packed {
        logic                  start;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
        logic [DIVISOR_W-1:0]  remainder;
    } t_div_rsp;

    // A register value of zero counts as one and anything above 64 as 64.
    function automatic logic [REG_W-1:0] clamp_reg(input logic [REG_W-1:0] v);
        logic [REG_W-1:0] r;
        if (v == '0) begin
            r = 7'd1;
        end else if (v > REG_MAX) begin
            r = REG_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/lmss_in_if.sv =====
// ----------------------------------------------------------------------------
// lmss_in_if
// Command channel of the scanner: pixel writes, gamma writes and scan steps.
// ----------------------------------------------------------------------------
interface lmss_in_if import lmss_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    op;
    logic [PIX_X_W-1:0] pixel_x;
    logic [PIX_Y_W-1:0] pixel_y;
    logic [VALUE_W-1:0] pixel_value;
    logic [VALUE_W-1:0] gamma_index;

    modport source (
        output valid, op, pixel_x, pixel_y, pixel_value, gamma_index,
        input  ready
    );
    modport sink (
        input  valid, op, pixel_x, pixel_y, pixel_value, gamma_index,
        output ready
    );
endinterface

// ===== rtl/core/lmss_out_if.sv =====
// ----------------------------------------------------------------------------
// lmss_out_if
// Column byte channel of the scanner, one beat per shift register byte.
// ----------------------------------------------------------------------------
interface lmss_out_if import lmss_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [VALUE_W-1:0]   out_byte;
    logic [ROW_OUT_W-1:0] active_row;
    logic                 latch_first;
    logic                 row_last;

    modport source (
        output valid, out_byte, active_row, latch_first, row_last,
        input  ready
    );
    modport sink (
        input  valid, out_byte, active_row, latch_first, row_last,
        output ready
    );
endinterface

// ===== rtl/core/lmss_div.sv =====
// ----------------------------------------------------------------------------
// lmss_div
// Restoring divider, one quotient bit per cycle, shared for modulo and
// threshold computation.
// ----------------------------------------------------------------------------
module lmss_div import lmss_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIVIDEND_W-1:0] r_quo;
    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;

    logic [DIVISOR_W:0]    trial;
    logic                  ge;
    logic [DIVISOR_W:0]    diff;

    assign trial = {r_rem, r_quo[DIVIDEND_W-1]};
    assign ge    = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // The dividend shifts out of the top of r_quo while quotient bits enter
    // at the bottom.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], ge};
            r_rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

// ===== rtl/core/led_matrix_subframe_scan.sv =====
// ----------------------------------------------------------------------------
// led_matrix_subframe_scan: threshold PWM row scanner for a grayscale matrix.
// Pixel and gamma writes are taken only while idle. A scan step holds the input
// for two divider runs, then per byte eight frame reads, the read pipeline and
// one emit, plus output stalls.
// After reset all PANEL_WIDTH*PANEL_HEIGHT frame store entries are cleared.
// ----------------------------------------------------------------------------
module led_matrix_subframe_scan import lmss_pkg::*; #(
    parameter int PANEL_WIDTH  = 120,
    parameter int PANEL_HEIGHT = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    lmss_in_if.sink              i_in_ch,
    lmss_out_if.source           o_out_ch,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_wdata
);

    localparam int DEPTH = PANEL_WIDTH * PANEL_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(PANEL_HEIGHT);
    localparam int BYTES = PANEL_WIDTH / 8;
    localparam int BIW   = (BYTES > 1) ? $clog2(BYTES) : 1;

    typedef enum logic [6:0] {
        S_CLEAR   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_MOD     = 7'b0000100,
        S_THR     = 7'b0001000,
        S_FETCH   = 7'b0010000,
        S_COLLECT = 7'b0100000,
        S_EMIT    = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    // Configuration and scan state.
    logic [REG_W-1:0]   r_subframe_total;
    logic [REG_W-1:0]   r_subframes_per_row;
    logic [5:0]         r_sub_cnt;
    logic [5:0]         r_row_sub;
    logic [RW-1:0]      r_row;
    logic [AW-1:0]      r_row_base;
    logic [REG_W-1:0]   r_tot;
    logic [VALUE_W-1:0] r_thr;
    logic [ROW_OUT_W-1:0] r_act;

    // Sequencer counters.
    logic [AW-1:0]      r_clr_addr;
    logic [AW-1:0]      r_addr;
    logic [BIW-1:0]     r_byte_idx;
    logic [2:0]         r_fet_cnt;
    logic [3:0]         r_col_cnt;
    logic [VALUE_W-1:0] r_acc;

    // Memories and read pipeline.
    logic [VALUE_W-1:0] r_frame [DEPTH];
    logic [VALUE_W-1:0] r_gamma [256];
    logic [255:0]       r_gvld;
    logic [VALUE_W-1:0] r_fs_q;
    logic [VALUE_W-1:0] r_g_data;
    logic [VALUE_W-1:0] r_g_idx;
    logic               r_g_hit;
    logic               r_p1_vld;
    logic               r_p2_vld;

    // Output register.
    logic                 r_out_valid;
    logic [VALUE_W-1:0]   r_out_byte;
    logic [ROW_OUT_W-1:0] r_out_row;
    logic                 r_out_first;
    logic                 r_out_last;

    t_div_req div_req;
    t_div_rsp div_rsp;

    logic               in_acc;
    logic               pix_ok;
    logic               fs_we;
    logic [AW-1:0]      fs_waddr;
    logic [VALUE_W-1:0] fs_wdata;
    logic [REG_W-1:0]   tot_now;
    logic [REG_W-1:0]   per_now;
    logic [RW-1:0]      act_row;
    logic [RW+3:0]      act_ext;
    logic [6:0]         odd;
    logic [VALUE_W-1:0] mapped;
    logic               out_free;
    logic               last_byte;
    logic [REG_W-1:0]   row_sub_inc;

    assign in_acc   = i_in_ch.valid && i_in_ch.ready;
    assign pix_ok   = (32'(i_in_ch.pixel_x) < 32'(PANEL_WIDTH))
                   && (32'(i_in_ch.pixel_y) < 32'(PANEL_HEIGHT));
    assign tot_now  = clamp_reg(r_subframe_total);
    assign per_now  = clamp_reg(r_subframes_per_row);
    assign out_free = !r_out_valid || o_out_ch.ready;
    assign last_byte = (r_byte_idx == '0);
    assign row_sub_inc = {1'b0, r_row_sub} + 7'd1;

    // The previous row drives on the first subframe of a row.
    always_comb begin
        if (r_row_sub == '0) begin
            act_row = (r_row == '0) ? RW'(PANEL_HEIGHT - 1) : r_row - 1'b1;
        end else begin
            act_row = r_row;
        end
        act_ext = {4'b0, act_row};
    end

    // 255*(2s+1) as a shift and subtract.
    assign odd = {div_rsp.remainder[5:0], 1'b1};

    always_comb begin
        div_req = '0;
        if (r_state == S_IDLE && in_acc && i_in_ch.op == OP_SCAN) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIVIDEND_W'({1'b0, r_sub_cnt} + 7'd1);
            div_req.divisor  = DIVISOR_W'(tot_now);
        end else if (r_state == S_MOD && div_rsp.done) begin
            div_req.start    = 1'b1;
            div_req.dividend = {odd, 8'b0} - {8'b0, odd};
            div_req.divisor  = {r_tot, 1'b0};
        end
    end

    lmss_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == AW'(DEPTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (in_acc && i_in_ch.op == OP_SCAN) n_state = S_MOD;
            end
            S_MOD: begin
                if (div_rsp.done) n_state = S_THR;
            end
            S_THR: begin
                if (div_rsp.done) n_state = S_FETCH;
            end
            S_FETCH: begin
                if (r_fet_cnt == 3'd7) n_state = S_COLLECT;
            end
            S_COLLECT: begin
                if (r_col_cnt == 4'd8) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = last_byte ? S_IDLE : S_FETCH;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign i_in_ch.ready = (r_state == S_IDLE);

    // Frame store: one write port shared by the clearing pass and pixel writes.
    always_comb begin
        fs_we    = 1'b0;
        fs_waddr = r_clr_addr;
        fs_wdata = '0;
        if (r_state == S_CLEAR) begin
            fs_we = 1'b1;
        end else if (in_acc && i_in_ch.op == OP_WR_PIXEL && pix_ok) begin
            fs_we    = 1'b1;
            fs_waddr = AW'(AW'(i_in_ch.pixel_y) * AW'(PANEL_WIDTH))
                     + AW'(i_in_ch.pixel_x);
            fs_wdata = i_in_ch.pixel_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fs_we) begin
            r_frame[fs_waddr] <= fs_wdata;
        end
        r_fs_q <= r_frame[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_in_ch.op == OP_WR_GAMMA) begin
            r_gamma[i_in_ch.gamma_index] <= i_in_ch.pixel_value;
        end
        r_g_data <= r_gamma[r_fs_q];
        r_g_idx  <= r_fs_q;
        r_g_hit  <= r_gvld[r_fs_q];
    end

    // An unwritten gamma entry reads as its own index.
    assign mapped = r_g_hit ? r_g_data : r_g_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state             <= S_CLEAR;
            r_subframe_total    <= REG_RESET;
            r_subframes_per_row <= REG_RESET;
            r_sub_cnt           <= '0;
            r_row_sub           <= '0;
            r_row               <= '0;
            r_row_base          <= '0;
            r_clr_addr          <= '0;
            r_gvld              <= '0;
            r_fet_cnt           <= '0;
            r_col_cnt           <= '0;
            r_p1_vld            <= 1'b0;
            r_p2_vld            <= 1'b0;
            r_out_valid         <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= (r_state == S_FETCH);
            r_p2_vld <= r_p1_vld;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SUBFRAME_TOTAL:    r_subframe_total    <= i_cfg_wdata;
                    CFG_SUBFRAMES_PER_ROW: r_subframes_per_row <= i_cfg_wdata;
                    default: ;
                endcase
            end

            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end

            if (in_acc && i_in_ch.op == OP_WR_GAMMA) begin
                r_gvld[i_in_ch.gamma_index] <= 1'b1;
            end

            if (r_state == S_MOD && div_rsp.done) begin
                r_sub_cnt <= div_rsp.remainder[5:0];
            end

            if (r_state == S_THR && div_rsp.done) begin
                r_fet_cnt <= '0;
                r_col_cnt <= '0;
            end

            if (r_state == S_FETCH) begin
                r_fet_cnt <= r_fet_cnt + 1'b1;
            end

            if (r_p2_vld) begin
                r_col_cnt <= r_col_cnt + 1'b1;
            end

            if (o_out_ch.ready) begin
                r_out_valid <= 1'b0;
            end

            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
                r_col_cnt   <= '0;
                r_fet_cnt   <= '0;
                if (last_byte) begin
                    if (row_sub_inc >= per_now) begin
                        r_row_sub <= '0;
                        if (r_row == RW'(PANEL_HEIGHT - 1)) begin
                            r_row      <= '0;
                            r_row_base <= '0;
                        end else begin
                            r_row      <= r_row + 1'b1;
                            r_row_base <= r_row_base + AW'(PANEL_WIDTH);
                        end
                    end else begin
                        r_row_sub <= row_sub_inc[5:0];
                    end
                end
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && in_acc && i_in_ch.op == OP_SCAN) begin
            r_tot <= tot_now;
            r_act <= act_ext[ROW_OUT_W-1:0];
        end

        if (r_state == S_THR && div_rsp.done) begin
            r_thr      <= div_rsp.quotient[VALUE_W-1:0];
            r_addr     <= r_row_base + AW'((BYTES - 1) * 8);
            r_byte_idx <= BIW'(BYTES - 1);
        end else if (r_state == S_FETCH) begin
            r_addr <= r_addr + 1'b1;
        end else if (r_state == S_EMIT && out_free && !last_byte) begin
            // The fetch left r_addr one byte past this one; step back two.
            r_addr     <= r_addr - AW'(16);
            r_byte_idx <= r_byte_idx - 1'b1;
        end

        // The lowest column of a byte lands in bit 7.
        if (r_p2_vld) begin
            r_acc <= {r_acc[VALUE_W-2:0], (mapped >= r_thr)};
        end

        if (r_state == S_EMIT && out_free) begin
            r_out_byte  <= r_acc;
            r_out_row   <= r_act;
            r_out_first <= (r_byte_idx == BIW'(BYTES - 1));
            r_out_last  <= last_byte;
        end
    end

    assign o_out_ch.valid       = r_out_valid;
    assign o_out_ch.out_byte    = r_out_byte;
    assign o_out_ch.active_row  = r_out_row;
    assign o_out_ch.latch_first = r_out_first;
    assign o_out_ch.row_last    = r_out_last;

endmodule
